### src/lfss_pkg.sv
// shared types, constants and helpers of the line follower steering and stop unit
package lfss_pkg;

   localparam int SPEED_W   = 11;
   localparam int WHEEL_W   = 13;
   localparam int SUM_W     = 14;
   localparam int DIST_W    = 32;
   localparam int TIMEOUT_W = 8;
   localparam int TICKS_W   = 9;
   localparam int CNT_W     = 2;
   localparam int MATH_W    = 13;
   localparam int CSR_IDX_W = 3;

   localparam logic [CNT_W-1:0]   DEBOUNCE_COUNT = CNT_W'(2);
   localparam logic [SUM_W-1:0]   ODO_SUM_LIMIT  = SUM_W'(2 * 1200);
   localparam logic [TICKS_W-1:0] TICKS_MAX      = '1;

   localparam logic [SPEED_W-1:0]   BASE_SPEED_RST   = SPEED_W'(900);
   localparam logic [SPEED_W-1:0]   LOST_SPEED_RST   = SPEED_W'(320);
   localparam logic [SPEED_W-1:0]   SOFT_STEER_RST   = SPEED_W'(300);
   localparam logic [SPEED_W-1:0]   HARD_STEER_RST   = SPEED_W'(450);
   localparam logic [SPEED_W-1:0]   LOST_STEER_RST   = SPEED_W'(170);
   localparam logic [SPEED_W-1:0]   MAX_TARGET_RST   = SPEED_W'(1700);
   localparam logic [DIST_W-1:0]    ARM_DISTANCE_RST = DIST_W'(2207200);
   localparam logic [TIMEOUT_W-1:0] SEQ_TIMEOUT_RST  = TIMEOUT_W'(30);

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_SPEED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFT_STEER   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HARD_STEER   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_STEER   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TARGET   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_DISTANCE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_TIMEOUT  = 3'd7;

   // sensor masks: bit2 left, bit1 middle, bit0 right
   localparam logic [2:0] MASK_NONE      = 3'b000;
   localparam logic [2:0] MASK_RIGHT     = 3'b001;
   localparam logic [2:0] MASK_MIDDLE    = 3'b010;
   localparam logic [2:0] MASK_RIGHT_MID = 3'b011;
   localparam logic [2:0] MASK_LEFT      = 3'b100;
   localparam logic [2:0] MASK_OUTER     = 3'b101;
   localparam logic [2:0] MASK_LEFT_MID  = 3'b110;
   localparam logic [2:0] MASK_ALL       = 3'b111;

   localparam int MASK_RIGHT_BIT  = 0;
   localparam int MASK_MIDDLE_BIT = 1;

   localparam logic signed [2:0] ERR_NONE = 3'sd0;
   localparam logic signed [2:0] ERR_SOFT = 3'sd1;
   localparam logic signed [2:0] ERR_HARD = 3'sd2;
   localparam logic signed [2:0] ERR_LOST = 3'sd3;

   typedef enum logic [1:0] {
      TURN_CENTER = 2'd0,
      TURN_LEFT   = 2'd1,
      TURN_RIGHT  = 2'd2
   } turn_type;

   typedef enum logic [2:0] {
      ST_WAIT_R   = 3'b001,
      ST_WAIT_M   = 3'b010,
      ST_STOPPED  = 3'b100
   } stop_state_type;

   typedef struct packed {
      logic [SPEED_W-1:0] base_speed;
      logic [SPEED_W-1:0] lost_speed;
      logic [SPEED_W-1:0] soft_steer;
      logic [SPEED_W-1:0] hard_steer;
      logic [SPEED_W-1:0] lost_steer;
      logic [SPEED_W-1:0] max_target;
   } steer_cfg_type;

   typedef struct packed {
      logic     line_found;
      turn_type prev_turn;
   } track_type;

   function automatic logic [SPEED_W-1:0] clamp_target(
      input logic signed [MATH_W-1:0] value,
      input logic [SPEED_W-1:0]       max_value
   );
      logic [SPEED_W-1:0] result;
      if (value < 0) begin
         result = '0;
      end else if (value[MATH_W-2:0] > {1'b0, max_value}) begin
         result = max_value;
      end else begin
         result = value[SPEED_W-1:0];
      end
      return result;
   endfunction

endpackage

### src/lfss_steer.sv
// mask decode, wheel target arithmetic and clamping
module lfss_steer
   import lfss_pkg::*;
(
   input  logic [2:0]          line_mask,
   input  logic                brake,
   input  steer_cfg_type       cfg,
   input  track_type           track,
   output track_type           track_next,
   output logic [SPEED_W-1:0]  right_target,
   output logic [SPEED_W-1:0]  left_target,
   output logic signed [2:0]   line_error
);

   logic signed [MATH_W-1:0] base_s;
   logic signed [MATH_W-1:0] lost_s;
   logic signed [MATH_W-1:0] soft_s;
   logic signed [MATH_W-1:0] hard_s;
   logic signed [MATH_W-1:0] lsteer_s;
   logic signed [MATH_W-1:0] right_raw;
   logic signed [MATH_W-1:0] left_raw;

   assign base_s   = $signed(MATH_W'(cfg.base_speed));
   assign lost_s   = $signed(MATH_W'(cfg.lost_speed));
   assign soft_s   = $signed(MATH_W'(cfg.soft_steer));
   assign hard_s   = $signed(MATH_W'(cfg.hard_steer));
   assign lsteer_s = $signed(MATH_W'(cfg.lost_steer));

   always_comb begin
      right_raw  = '0;
      left_raw   = '0;
      line_error = ERR_NONE;
      track_next = track;
      if (!brake) begin
         case (line_mask) inside
            MASK_MIDDLE, MASK_ALL: begin
               track_next.line_found = 1'b1;
               track_next.prev_turn  = TURN_CENTER;
               right_raw = base_s;
               left_raw  = base_s;
            end
            MASK_LEFT_MID: begin
               track_next.line_found = 1'b1;
               track_next.prev_turn  = TURN_LEFT;
               line_error = -ERR_SOFT;
               right_raw  = base_s + soft_s;
               left_raw   = base_s - soft_s;
            end
            MASK_LEFT: begin
               track_next.line_found = 1'b1;
               track_next.prev_turn  = TURN_LEFT;
               line_error = -ERR_HARD;
               right_raw  = base_s + hard_s;
               left_raw   = base_s - hard_s;
            end
            MASK_RIGHT_MID: begin
               track_next.line_found = 1'b1;
               track_next.prev_turn  = TURN_RIGHT;
               line_error = ERR_SOFT;
               right_raw  = base_s - soft_s;
               left_raw   = base_s + soft_s;
            end
            MASK_RIGHT: begin
               track_next.line_found = 1'b1;
               track_next.prev_turn  = TURN_RIGHT;
               line_error = ERR_HARD;
               right_raw  = base_s - hard_s;
               left_raw   = base_s + hard_s;
            end
            MASK_NONE: begin
               // search toward the side the line was last seen on; halt if it was never seen
               if (!track.line_found) begin
                  right_raw = '0;
                  left_raw  = '0;
               end else if (track.prev_turn == TURN_LEFT) begin
                  line_error = -ERR_LOST;
                  right_raw  = lost_s + lsteer_s;
                  left_raw   = lost_s - lsteer_s;
               end else if (track.prev_turn == TURN_RIGHT) begin
                  line_error = ERR_LOST;
                  right_raw  = lost_s - lsteer_s;
                  left_raw   = lost_s + lsteer_s;
               end else begin
                  right_raw = lost_s;
                  left_raw  = lost_s;
               end
            end
            default: begin
               // outer pair only: halt
               right_raw = '0;
               left_raw  = '0;
            end
         endcase
      end
   end

   assign right_target = clamp_target(right_raw, cfg.max_target);
   assign left_target  = clamp_target(left_raw, cfg.max_target);

endmodule

### src/line_follow_steer_stop_unit.sv
// top level of the line follower: odometry, stop-line detector, steering, handshakes
// a request goes into the input register, then into the response register
// throughput: one request per cycle while no response is stalled; input and response
// registers hold one request each; one more is taken while a response is stalled
// reset (synchronous, active high) restores all csr values to their defaults and
// clears odometry, arming, the stop detector and the line tracking state
module line_follow_steer_stop_unit
   import lfss_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_line_mask,
   input  logic signed [WHEEL_W-1:0]  req_right_wheel_speed,
   input  logic signed [WHEEL_W-1:0]  req_left_wheel_speed,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [SPEED_W-1:0]         rsp_right_target,
   output logic [SPEED_W-1:0]         rsp_left_target,
   output logic                       rsp_brake,
   output logic signed [2:0]          rsp_line_error,
   output logic                       rsp_stop_armed,
   output logic                       rsp_stopped,
   output logic [DIST_W-1:0]          rsp_travelled,
   // csr write channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [DIST_W-1:0]          csr_wdata
);

   // ---------------------------------------------------------------- csr
   steer_cfg_type         cfg_ff;
   logic [DIST_W-1:0]     arm_distance_ff;
   logic [TIMEOUT_W-1:0]  seq_timeout_ff;

   // csr writes land in the registers directly, the port never pushes back
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_speed <= BASE_SPEED_RST;
         cfg_ff.lost_speed <= LOST_SPEED_RST;
         cfg_ff.soft_steer <= SOFT_STEER_RST;
         cfg_ff.hard_steer <= HARD_STEER_RST;
         cfg_ff.lost_steer <= LOST_STEER_RST;
         cfg_ff.max_target <= MAX_TARGET_RST;
         arm_distance_ff   <= ARM_DISTANCE_RST;
         seq_timeout_ff    <= SEQ_TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BASE_SPEED:   cfg_ff.base_speed <= csr_wdata[SPEED_W-1:0];
            CSR_LOST_SPEED:   cfg_ff.lost_speed <= csr_wdata[SPEED_W-1:0];
            CSR_SOFT_STEER:   cfg_ff.soft_steer <= csr_wdata[SPEED_W-1:0];
            CSR_HARD_STEER:   cfg_ff.hard_steer <= csr_wdata[SPEED_W-1:0];
            CSR_LOST_STEER:   cfg_ff.lost_steer <= csr_wdata[SPEED_W-1:0];
            CSR_MAX_TARGET:   cfg_ff.max_target <= csr_wdata[SPEED_W-1:0];
            CSR_ARM_DISTANCE: arm_distance_ff   <= csr_wdata;
            CSR_SEQ_TIMEOUT:  seq_timeout_ff    <= csr_wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // two-slot pipeline: input register, then response register; the tick's
   // state update happens when a request moves from the first to the second
   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic [2:0]                 mask_ff;
   logic signed [WHEEL_W-1:0]  rspeed_ff;
   logic signed [WHEEL_W-1:0]  lspeed_ff;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic                       advance;
   logic                       req_take;

   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // request payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         mask_ff   <= req_line_mask;
         rspeed_ff <= req_right_wheel_speed;
         lspeed_ff <= req_left_wheel_speed;
      end
   end

   // ---------------------------------------------------------------- odometry
   logic [DIST_W-1:0]   dist_ff;
   logic [DIST_W-1:0]   dist_in;
   logic                armed_ff;
   logic                armed_in;
   logic [WHEEL_W-1:0]  rabs;
   logic [WHEEL_W-1:0]  labs;
   logic [SUM_W-1:0]    speed_sum;
   logic [DIST_W:0]     dist_sum;

   // magnitude fits 13 bits unsigned even for the most negative speed
   assign rabs      = rspeed_ff[WHEEL_W-1] ? WHEEL_W'(-rspeed_ff) : WHEEL_W'(rspeed_ff);
   assign labs      = lspeed_ff[WHEEL_W-1] ? WHEEL_W'(-lspeed_ff) : WHEEL_W'(lspeed_ff);
   assign speed_sum = SUM_W'(rabs) + SUM_W'(labs);
   assign dist_sum  = {1'b0, dist_ff} + (DIST_W + 1)'(speed_sum);

   always_comb begin
      dist_in = dist_ff;
      // implausible speed sums (wheel slip, glitches) are dropped
      if (speed_sum <= ODO_SUM_LIMIT) begin
         dist_in = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
      end
   end

   // arming is sticky, even when arm_distance is raised later
   assign armed_in = armed_ff || (dist_in >= arm_distance_ff);

   // ---------------------------------------------------------------- stop detector
   stop_state_type       stop_ff;
   stop_state_type       stop_in;
   logic [CNT_W-1:0]     rcnt_ff;
   logic [CNT_W-1:0]     rcnt_in;
   logic [CNT_W-1:0]     mcnt_ff;
   logic [CNT_W-1:0]     mcnt_in;
   logic [TICKS_W-1:0]   ticks_ff;
   logic [TICKS_W-1:0]   ticks_in;
   logic [CNT_W-1:0]     rcnt_upd;
   logic [CNT_W-1:0]     mcnt_upd;
   logic [TICKS_W-1:0]   ticks_upd;
   logic                 right_only;
   logic                 middle_on;
   logic                 stopping;

   assign right_only = mask_ff[MASK_RIGHT_BIT] && !mask_ff[MASK_MIDDLE_BIT];
   assign middle_on  = mask_ff[MASK_MIDDLE_BIT];

   // debounce counters saturate at the debounce count
   assign rcnt_upd  = !right_only ? '0 :
                      (rcnt_ff >= DEBOUNCE_COUNT) ? rcnt_ff : rcnt_ff + CNT_W'(1);
   assign mcnt_upd  = !middle_on ? '0 :
                      (mcnt_ff >= DEBOUNCE_COUNT) ? mcnt_ff : mcnt_ff + CNT_W'(1);
   assign ticks_upd = (ticks_ff == TICKS_MAX) ? ticks_ff : ticks_ff + TICKS_W'(1);

   always_comb begin
      stop_in  = stop_ff;
      rcnt_in  = rcnt_ff;
      mcnt_in  = mcnt_ff;
      ticks_in = ticks_ff;
      stopping = 1'b0;
      unique case (stop_ff)
         ST_STOPPED: begin
            // latched until reset
            stopping = 1'b1;
         end
         ST_WAIT_R: begin
            if (!armed_in) begin
               rcnt_in  = '0;
               mcnt_in  = '0;
               ticks_in = '0;
            end else if (mask_ff == MASK_ALL) begin
               // all black: stop at once (zero stop offset)
               stop_in  = ST_STOPPED;
               stopping = 1'b1;
            end else begin
               rcnt_in = rcnt_upd;
               if (rcnt_upd >= DEBOUNCE_COUNT) begin
                  stop_in  = ST_WAIT_M;
                  mcnt_in  = '0;
                  ticks_in = '0;
               end
            end
         end
         ST_WAIT_M: begin
            if (!armed_in) begin
               stop_in  = ST_WAIT_R;
               rcnt_in  = '0;
               mcnt_in  = '0;
               ticks_in = '0;
            end else if (mask_ff == MASK_ALL) begin
               stop_in  = ST_STOPPED;
               stopping = 1'b1;
            end else if (mcnt_upd >= DEBOUNCE_COUNT) begin
               // right then middle confirmed: the stop latches on this tick
               stop_in  = ST_STOPPED;
               stopping = 1'b1;
               mcnt_in  = mcnt_upd;
               ticks_in = ticks_upd;
            end else if (ticks_upd > TICKS_W'(seq_timeout_ff)) begin
               // middle came too late, start over
               stop_in  = ST_WAIT_R;
               rcnt_in  = '0;
               mcnt_in  = '0;
               ticks_in = '0;
            end else begin
               mcnt_in  = mcnt_upd;
               ticks_in = ticks_upd;
            end
         end
         default: begin
            stop_in  = ST_WAIT_R;
            rcnt_in  = '0;
            mcnt_in  = '0;
            ticks_in = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------- steering
   track_type            track_ff;
   track_type            track_in;
   logic [SPEED_W-1:0]   right_target;
   logic [SPEED_W-1:0]   left_target;
   logic signed [2:0]    line_error;

   lfss_steer u_steer (
      .line_mask    (mask_ff),
      .brake        (stopping),
      .cfg          (cfg_ff),
      .track        (track_ff),
      .track_next   (track_in),
      .right_target (right_target),
      .left_target  (left_target),
      .line_error   (line_error)
   );

   // ---------------------------------------------------------------- tick state
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff   <= '0;
         armed_ff  <= 1'b0;
         stop_ff   <= ST_WAIT_R;
         rcnt_ff   <= '0;
         mcnt_ff   <= '0;
         ticks_ff  <= '0;
         track_ff  <= '{line_found: 1'b0, prev_turn: TURN_CENTER};
      end else if (advance) begin
         dist_ff   <= dist_in;
         armed_ff  <= armed_in;
         stop_ff   <= stop_in;
         rcnt_ff   <= rcnt_in;
         mcnt_ff   <= mcnt_in;
         ticks_ff  <= ticks_in;
         track_ff  <= track_in;
      end
   end

   // ---------------------------------------------------------------- response register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_right_target <= right_target;
         rsp_left_target  <= left_target;
         rsp_brake        <= stopping;
         rsp_line_error   <= line_error;
         rsp_stop_armed   <= armed_in;
         rsp_stopped      <= stopping;
         rsp_travelled    <= dist_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   // ---------------------------------------------------------------- assertions
   a_brake_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_brake) |->
         (rsp_right_target == '0 && rsp_left_target == '0 && rsp_line_error == ERR_NONE))
      else $error("braked response carries nonzero targets or error");

   a_stop_needs_arm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stopped) |-> rsp_stop_armed)
      else $error("stop latched without the detector armed");

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      (stop_ff == ST_STOPPED) |=> (stop_ff == ST_STOPPED))
      else $error("latched stop released without reset");

   a_armed_sticky: assert property (@(posedge clock) disable iff (reset)
      armed_ff |=> armed_ff)
      else $error("armed flag cleared without reset");

endmodule

### dv/lfss_steer_checker.sv
// checker for the line follower: tracks requests and csr writes, predicts and compares responses
module lfss_steer_checker
   import lfss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [2:0]                req_line_mask,
   input  logic signed [WHEEL_W-1:0] req_right_wheel_speed,
   input  logic signed [WHEEL_W-1:0] req_left_wheel_speed,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [SPEED_W-1:0]        rsp_right_target,
   input  logic [SPEED_W-1:0]        rsp_left_target,
   input  logic                      rsp_brake,
   input  logic signed [2:0]         rsp_line_error,
   input  logic                      rsp_stop_armed,
   input  logic                      rsp_stopped,
   input  logic [DIST_W-1:0]         rsp_travelled,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [DIST_W-1:0]         csr_wdata,
   output int                        failures,
   output int                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      SEQ_WAIT_RIGHT,
      SEQ_WAIT_MIDDLE,
      SEQ_CONFIRMED,
      SEQ_STOPPED
   } seq_state_type;

   typedef struct packed {
      logic [SPEED_W-1:0] right_target;
      logic [SPEED_W-1:0] left_target;
      logic               brake;
      logic signed [2:0]  line_error;
      logic               stop_armed;
      logic               stopped;
      logic [DIST_W-1:0]  travelled;
   } tick_result_type;

   steer_cfg_type          cfg;
   logic [DIST_W-1:0]      arm_at;
   logic [TIMEOUT_W-1:0]   timeout_ticks;

   turn_type               prev_turn;
   logic                   line_found;
   seq_state_type          seq_state;
   logic [DIST_W-1:0]      odo_total;
   logic                   armed;
   logic [CNT_W-1:0]       right_cnt;
   logic [CNT_W-1:0]       middle_cnt;
   logic [TICKS_W-1:0]     wait_ticks;

   tick_result_type        pending_ticks[$];

   function automatic void restart_sequence();
      seq_state  = SEQ_WAIT_RIGHT;
      right_cnt  = '0;
      middle_cnt = '0;
      wait_ticks = '0;
   endfunction

   function automatic logic [SPEED_W-1:0] clamp_speed(input int cmd);
      logic [SPEED_W-1:0] speed;
      if (cmd < 0) begin
         speed = '0;
      end else if (cmd > int'(cfg.max_target)) begin
         speed = cfg.max_target;
      end else begin
         speed = SPEED_W'(cmd);
      end
      return speed;
   endfunction

   function automatic tick_result_type follow_line_tick(
      input logic [2:0]                mask,
      input logic signed [WHEEL_W-1:0] rs,
      input logic signed [WHEEL_W-1:0] ls
   );
      tick_result_type   res;
      int                speed_sum;
      int                right_cmd;
      int                left_cmd;
      int                corr;
      logic [DIST_W:0]   odo_next;
      logic              latched;
      logic signed [2:0] err;

      // odometry, skipped on implausible speed sums, saturating
      speed_sum = (rs < 0 ? -int'(rs) : int'(rs)) + (ls < 0 ? -int'(ls) : int'(ls));
      if (speed_sum <= int'(ODO_SUM_LIMIT)) begin
         odo_next  = {1'b0, odo_total} + (DIST_W + 1)'(speed_sum);
         odo_total = odo_next[DIST_W] ? '1 : odo_next[DIST_W-1:0];
      end
      if (odo_total >= arm_at) begin
         armed = 1'b1;
      end

      latched = 1'b0;
      if (seq_state == SEQ_STOPPED) begin
         latched = 1'b1;
      end else if (!armed) begin
         restart_sequence();
      end else begin
         if (mask == MASK_ALL) begin
            seq_state = SEQ_CONFIRMED;
         end
         case (seq_state)
            SEQ_WAIT_RIGHT: begin
               if (mask[MASK_RIGHT_BIT] && !mask[MASK_MIDDLE_BIT]) begin
                  if (right_cnt < DEBOUNCE_COUNT) right_cnt++;
               end else begin
                  right_cnt = '0;
               end
               if (right_cnt >= DEBOUNCE_COUNT) begin
                  seq_state  = SEQ_WAIT_MIDDLE;
                  middle_cnt = '0;
                  wait_ticks = '0;
               end
            end
            SEQ_WAIT_MIDDLE: begin
               if (wait_ticks < TICKS_MAX) wait_ticks++;
               if (mask[MASK_MIDDLE_BIT]) begin
                  if (middle_cnt < DEBOUNCE_COUNT) middle_cnt++;
               end else begin
                  middle_cnt = '0;
               end
               if (middle_cnt >= DEBOUNCE_COUNT) begin
                  seq_state = SEQ_CONFIRMED;
               end else if (wait_ticks > {1'b0, timeout_ticks}) begin
                  restart_sequence();
               end
            end
            default: begin
            end
         endcase
         // zero stop offset: a confirmed line stops on the confirming tick
         if (seq_state == SEQ_CONFIRMED) begin
            seq_state = SEQ_STOPPED;
            latched   = 1'b1;
         end
      end

      right_cmd = 0;
      left_cmd  = 0;
      err       = ERR_NONE;
      if (!latched) begin
         case (mask)
            MASK_MIDDLE, MASK_ALL: begin
               line_found = 1'b1;
               prev_turn  = TURN_CENTER;
               right_cmd  = int'(cfg.base_speed);
               left_cmd   = int'(cfg.base_speed);
            end
            MASK_LEFT_MID, MASK_LEFT: begin
               corr       = int'(mask == MASK_LEFT_MID ? cfg.soft_steer : cfg.hard_steer);
               err        = (mask == MASK_LEFT_MID) ? -ERR_SOFT : -ERR_HARD;
               line_found = 1'b1;
               prev_turn  = TURN_LEFT;
               right_cmd  = int'(cfg.base_speed) + corr;
               left_cmd   = int'(cfg.base_speed) - corr;
            end
            MASK_RIGHT_MID, MASK_RIGHT: begin
               corr       = int'(mask == MASK_RIGHT_MID ? cfg.soft_steer : cfg.hard_steer);
               err        = (mask == MASK_RIGHT_MID) ? ERR_SOFT : ERR_HARD;
               line_found = 1'b1;
               prev_turn  = TURN_RIGHT;
               right_cmd  = int'(cfg.base_speed) - corr;
               left_cmd   = int'(cfg.base_speed) + corr;
            end
            MASK_NONE: begin
               corr = int'(cfg.lost_steer);
               if (!line_found) begin
                  right_cmd = 0;
               end else if (prev_turn == TURN_LEFT) begin
                  err       = -ERR_LOST;
                  right_cmd = int'(cfg.lost_speed) + corr;
                  left_cmd  = int'(cfg.lost_speed) - corr;
               end else if (prev_turn == TURN_RIGHT) begin
                  err       = ERR_LOST;
                  right_cmd = int'(cfg.lost_speed) - corr;
                  left_cmd  = int'(cfg.lost_speed) + corr;
               end else begin
                  right_cmd = int'(cfg.lost_speed);
                  left_cmd  = int'(cfg.lost_speed);
               end
            end
            default: begin
            end
         endcase
      end

      res.right_target = clamp_speed(right_cmd);
      res.left_target  = clamp_speed(left_cmd);
      res.brake        = latched;
      res.line_error   = err;
      res.stop_armed   = armed;
      res.stopped      = (seq_state == SEQ_STOPPED);
      res.travelled    = odo_total;
      return res;
   endfunction

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         failures++;
      end
   endtask

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      tick_result_type want;
      if (reset) begin
         cfg = {BASE_SPEED_RST, LOST_SPEED_RST, SOFT_STEER_RST,
                HARD_STEER_RST, LOST_STEER_RST, MAX_TARGET_RST};
         arm_at        = ARM_DISTANCE_RST;
         timeout_ticks = SEQ_TIMEOUT_RST;
         prev_turn     = TURN_CENTER;
         line_found    = 1'b0;
         odo_total     = '0;
         armed         = 1'b0;
         restart_sequence();
         pending_ticks.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_SPEED:   cfg.base_speed = csr_wdata[SPEED_W-1:0];
               CSR_LOST_SPEED:   cfg.lost_speed = csr_wdata[SPEED_W-1:0];
               CSR_SOFT_STEER:   cfg.soft_steer = csr_wdata[SPEED_W-1:0];
               CSR_HARD_STEER:   cfg.hard_steer = csr_wdata[SPEED_W-1:0];
               CSR_LOST_STEER:   cfg.lost_steer = csr_wdata[SPEED_W-1:0];
               CSR_MAX_TARGET:   cfg.max_target = csr_wdata[SPEED_W-1:0];
               CSR_ARM_DISTANCE: arm_at = csr_wdata;
               CSR_SEQ_TIMEOUT:  timeout_ticks = csr_wdata[TIMEOUT_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_ticks.size() == 0) begin
               $error("response with no request waiting");
               failures++;
            end else begin
               want = pending_ticks.pop_front();
               check_field("right_target", want.right_target, rsp_right_target);
               check_field("left_target", want.left_target, rsp_left_target);
               check_field("brake", want.brake, rsp_brake);
               check_field("line_error", $signed(want.line_error), rsp_line_error);
               check_field("stop_armed", want.stop_armed, rsp_stop_armed);
               check_field("stopped", want.stopped, rsp_stopped);
               check_field("travelled", want.travelled, rsp_travelled);
            end
         end
         if (req_valid && !req_stall) begin
            pending_ticks.push_back(follow_line_tick(req_line_mask, req_right_wheel_speed,
                                                     req_left_wheel_speed));
         end
      end
      outstanding = pending_ticks.size();
   end

endmodule

### dv/tb.sv
// top of the line follower testbench: clock, reset, stimulus, receiver stalls and verdict
module tb
   import lfss_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 60;    // long receiver hold-off, fills both registers
   localparam int WATCHDOG_LIMIT = 4000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [2:0]                req_line_mask = MASK_NONE;
   logic signed [WHEEL_W-1:0] req_right_wheel_speed = '0;
   logic signed [WHEEL_W-1:0] req_left_wheel_speed = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [SPEED_W-1:0]        rsp_right_target;
   logic [SPEED_W-1:0]        rsp_left_target;
   logic                      rsp_brake;
   logic signed [2:0]         rsp_line_error;
   logic                      rsp_stop_armed;
   logic                      rsp_stopped;
   logic [DIST_W-1:0]         rsp_travelled;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_BASE_SPEED;
   logic [DIST_W-1:0]         csr_wdata = '0;

   int failures;
   int outstanding;

   // idling percentages of the current phase
   int sender_idle_pct   = 23;
   int receiver_idle_pct = 67;

   // long hold-off handshake between stimulus and the stall process
   int hold_orders = 0;
   int hold_taken  = 0;
   int hold_left   = 0;

   int quiet_cycles = 0;

   // detector bookkeeping for the stimulus: timeout in force and whether the
   // last request saw the middle sensor (two in a row would confirm a stop line)
   int seq_timeout_now = 30;
   bit last_had_middle = 1'b0;

   line_follow_steer_stop_unit u_dut (.*);

   lfss_steer_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog: cycles with no request, response or csr write accepted
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stalls, plus a long hold-off whenever stimulus orders one
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_orders != hold_taken) begin
         hold_taken = hold_orders;
         hold_left  = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // wheel speed: mostly plausible so odometry counts, sometimes the full field
   function automatic int random_speed();
      int speed;
      if ($urandom_range(9) < 7) begin
         speed = int'($urandom_range(2400)) - 1200;
      end else begin
         speed = int'($urandom_range(8191)) - 4096;
      end
      return speed;
   endfunction

   // one control tick; gaps in front of it at the sender's idle rate
   task automatic send_tick(input logic [2:0] mask, input int rs, input int ls);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid             <= 1'b0;
         req_line_mask         <= 3'($urandom());
         req_right_wheel_speed <= WHEEL_W'($urandom());
         req_left_wheel_speed  <= WHEEL_W'($urandom());
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_line_mask         <= mask;
      req_right_wheel_speed <= WHEEL_W'(rs);
      req_left_wheel_speed  <= WHEEL_W'(ls);
      last_had_middle = mask[MASK_MIDDLE_BIT];
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering requests and wait until every response is back;
   // the checker's count is updated on the clock edge, so it is read only after an edge
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_config(
      input logic [SPEED_W-1:0]   base,
      input logic [SPEED_W-1:0]   lost,
      input logic [SPEED_W-1:0]   soft_corr,
      input logic [SPEED_W-1:0]   hard,
      input logic [SPEED_W-1:0]   lsteer,
      input logic [SPEED_W-1:0]   ceiling,
      input logic [DIST_W-1:0]    arm_at,
      input logic [TIMEOUT_W-1:0] tmo
   );
      settle();
      write_reg(CSR_BASE_SPEED, DIST_W'(base));
      write_reg(CSR_LOST_SPEED, DIST_W'(lost));
      write_reg(CSR_SOFT_STEER, DIST_W'(soft_corr));
      write_reg(CSR_HARD_STEER, DIST_W'(hard));
      write_reg(CSR_LOST_STEER, DIST_W'(lsteer));
      write_reg(CSR_MAX_TARGET, DIST_W'(ceiling));
      write_reg(CSR_ARM_DISTANCE, arm_at);
      write_reg(CSR_SEQ_TIMEOUT, DIST_W'(tmo));
      csr_valid <= 1'b0;
      seq_timeout_now = int'(tmo);
   endtask

   task automatic random_config(input logic [DIST_W-1:0]    arm_at,
                                input logic [TIMEOUT_W-1:0] tmo);
      apply_config(SPEED_W'($urandom_range(2047)), SPEED_W'($urandom_range(2047)),
                   SPEED_W'($urandom_range(2047)), SPEED_W'($urandom_range(2047)),
                   SPEED_W'($urandom_range(2047)), SPEED_W'($urandom_range(2047)),
                   arm_at, tmo);
   endtask

   // free steering: any mask, any speeds
   task automatic steer_burst(input int count);
      repeat (count) send_tick(3'($urandom_range(7)), random_speed(), random_speed());
   endtask

   // armed driving: right-only sightings followed by a window of random masks,
   // mixed with noise; never two middle sightings in a row and never all black,
   // so the detector walks its states and times out without latching a stop
   task automatic patrol_stop_line(input int count);
      int          sent;
      int          window;
      logic [2:0]  mask;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(3) != 0) begin
            repeat ($urandom_range(3, 2)) begin
               send_tick($urandom_range(1) ? MASK_RIGHT : MASK_OUTER, random_speed(),
                         random_speed());
               sent++;
            end
            window = $urandom_range(seq_timeout_now > 37 ? 40 : seq_timeout_now + 3);
         end else begin
            window = $urandom_range(6);
         end
         repeat (window) begin
            do mask = 3'($urandom_range(6)); while (last_had_middle && mask[MASK_MIDDLE_BIT]);
            send_tick(mask, random_speed(), random_speed());
            sent++;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, reset values: nothing seen yet, then every steering case
      send_tick(MASK_NONE, 0, 0);
      send_tick(MASK_OUTER, 4095, -4096);
      send_tick(MASK_MIDDLE, 1200, 1200);        // sum right at the odometry limit
      send_tick(MASK_LEFT_MID, -1201, 1200);     // one over, not counted
      send_tick(MASK_LEFT, -1, -1);
      send_tick(MASK_NONE, 0, 4095);             // search toward the left
      send_tick(MASK_RIGHT_MID, -4096, 0);
      send_tick(MASK_RIGHT, 2047, -2048);
      send_tick(MASK_NONE, 600, 600);            // search toward the right
      send_tick(MASK_ALL, 1, 1);                 // all black before arming drives straight
      send_tick(MASK_NONE, 1000, -1000);         // centered search
      // stop sequence before arming is ignored
      send_tick(MASK_RIGHT, 100, 100);
      send_tick(MASK_RIGHT, 100, 100);
      send_tick(MASK_MIDDLE, 100, 100);
      send_tick(MASK_MIDDLE, 100, 100);

      // top of every range but the lost speed, which is zero: targets clamp, search goes negative
      apply_config('1, '0, '1, '1, '1, '1, '1, '1);
      send_tick(MASK_MIDDLE, 0, 0);
      send_tick(MASK_LEFT, 0, 0);
      send_tick(MASK_NONE, 0, 0);
      send_tick(MASK_RIGHT_MID, 0, 0);

      // mostly bottom of the ranges, ceiling at zero: everything clamps to zero
      apply_config('0, '1, '0, '1, '0, '0, '1, '0);
      send_tick(MASK_LEFT, 300, -300);
      send_tick(MASK_NONE, 300, -300);
      send_tick(MASK_MIDDLE, 300, -300);

      // phase one: sender idles little, receiver a lot; stays unarmed
      random_config($urandom_range(32'hFFFF_FFFF, 32'd2_000_000),
                    TIMEOUT_W'($urandom_range(255)));
      hold_orders++;
      steer_burst(90);
      random_config($urandom_range(32'hFFFF_FFFF, 32'd2_000_000),
                    TIMEOUT_W'($urandom_range(255)));
      steer_burst(90);

      // phase two: the other way round; arm halfway through
      sender_idle_pct   = 67;
      receiver_idle_pct = 23;
      random_config($urandom_range(32'hFFFF_FFFF, 32'd2_000_000),
                    TIMEOUT_W'($urandom_range(255)));
      hold_orders++;
      steer_burst(90);
      random_config('0, TIMEOUT_W'($urandom_range(12)));
      patrol_stop_line(90);

      // phase three: no idling; arm distance raised, armed flag must stay
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      random_config('1, '0);
      hold_orders++;
      patrol_stop_line(90);
      random_config('1, TIMEOUT_W'($urandom_range(12, 1)));
      patrol_stop_line(60);

      // latch the stop line, by all black or by a right-then-middle sequence
      random_config('1, '1);
      if ($urandom_range(1) != 0) begin
         send_tick(MASK_ALL, random_speed(), random_speed());
      end else begin
         repeat (2) begin
            send_tick(MASK_RIGHT, random_speed(), random_speed());
            send_tick(MASK_RIGHT, random_speed(), random_speed());
            send_tick(MASK_MIDDLE, random_speed(), random_speed());
            send_tick(MASK_RIGHT_MID, random_speed(), random_speed());
         end
      end
      // stopped for good: brake held, odometry still runs
      steer_burst(25);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
src/lfss_pkg.sv
src/lfss_steer.sv
src/line_follow_steer_stop_unit.sv
dv/lfss_steer_checker.sv
dv/tb.sv
